// File: rtl/assert_macros.svh
// Assertion macros used by the color converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a sequence that starts in the cycle of ante.
`define ASSERT_SEQ(label, clk, rst, ante, seq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> seq) \
    else $error(msg);

`endif

// File: rtl/hsv_pkg.sv
// Types and constants of the HSV to GRB color converter.
`default_nettype none
package hsv_pkg;

  typedef struct packed {
    logic [8:0] hue_deg;
    logic [6:0] sat_pct;
    logic [6:0] val_pct;
  } hsv_t;

  typedef struct packed {
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] blue;
  } grb_t;

  // Channel numerators share the denominator 600000; 600000 fits in 20 bits.
  localparam int NUM_W = 20;

  localparam logic [8:0]       HUE_FULL   = 9'd360;
  localparam logic [8:0]       SECTOR_DEG = 9'd60;
  localparam logic [6:0]       PCT_MAX    = 7'd100;
  localparam logic [NUM_W-1:0] V_SCALE    = 20'd6000;
  localparam logic [NUM_W-1:0] VS_SCALE   = 20'd60;

  // byte = floor(num * 255 / 600000) = floor(num * 17 / 40000)
  localparam logic [4:0]  BYTE_MUL  = 5'd17;
  localparam logic [15:0] BYTE_DEN  = 16'd40000;
  // 17 * floor(2^32 / 40000); the estimate is low by at most one
  localparam logic [20:0] BYTE_RECIP = 21'd1825358;

  localparam logic [2:0] SEC_0 = 3'd0;
  localparam logic [2:0] SEC_1 = 3'd1;
  localparam logic [2:0] SEC_2 = 3'd2;
  localparam logic [2:0] SEC_3 = 3'd3;
  localparam logic [2:0] SEC_4 = 3'd4;
  localparam logic [2:0] SEC_5 = 3'd5;

endpackage
`default_nettype wire

// File: rtl/hsv_scale.sv
// Two-stage scaler: channel numerator over 600000 to a byte.
`default_nettype none
module hsv_scale import hsv_pkg::*; (
  input  wire logic             clk,
  input  wire logic [NUM_W-1:0] num,
  output logic      [7:0]       chan
);

  logic [23:0] x;
  logic [8:0]  q0;
  logic [40:0] est;
  logic [24:0] back;
  logic [23:0] rem;

  assign est = 41'(num) * 41'(BYTE_RECIP);

  always_ff @(posedge clk) begin
    x  <= 24'(num) * 24'(BYTE_MUL);
    q0 <= est[40:32];
  end

  // estimate is low by at most one: one compare fixes it
  assign back = 25'(q0) * 25'(BYTE_DEN);
  assign rem  = x - back[23:0];

  always_ff @(posedge clk) begin
    if (rem >= 24'(BYTE_DEN)) begin
      chan <= 8'(q0 + 9'd1);
    end else begin
      chan <= q0[7:0];
    end
  end

endmodule
`default_nettype wire

// File: rtl/hsv_to_grb_color_converter.sv
// An accepted beat reaches done and grb through the registered hue, product, numerator, scale and routing stages.
// Throughput: one beat per cycle, set by the fully pipelined multiply and scale stages.
// busy is held low; the receiver cannot stall, so no beat ever waits.
// Reset (rst, synchronous, active high) clears the valid bits; data registers keep state.
`default_nettype none
`include "assert_macros.svh"
module hsv_to_grb_color_converter import hsv_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire hsv_t hsv,
  output logic      done,
  output grb_t      grb
);

  localparam int LAT = 6;

  // stage 1: hue reduction, clamping, sector and triangle term
  logic [8:0] h;
  logic [6:0] s_c;
  logic [6:0] v_c;
  logic [2:0] sec;
  logic [8:0] off;
  logic [5:0] t_c;

  logic [6:0] s1_s;
  logic [6:0] s1_v;
  logic [5:0] s1_t;
  logic [2:0] s1_sec;

  logic [13:0]      s2_vs;
  logic [NUM_W-1:0] s2_v6000;
  logic [5:0]       s2_t;
  logic [2:0]       s2_sec;

  logic [NUM_W-1:0] lo_next;
  logic [NUM_W-1:0] mid_next;
  logic [NUM_W-1:0] hi_n;
  logic [NUM_W-1:0] lo_n;
  logic [NUM_W-1:0] mid_n;
  logic [2:0]       s3_sec;

  logic [2:0] s4_sec;
  logic [2:0] s5_sec;
  logic [7:0] hi_b;
  logic [7:0] lo_b;
  logic [7:0] mid_b;

  logic [4:0] vld;
  grb_t       grb_next;

  assign busy = 1'b0;

  always_comb begin
    h   = (hsv.hue_deg >= HUE_FULL) ? hsv.hue_deg - HUE_FULL : hsv.hue_deg;
    s_c = (hsv.sat_pct > PCT_MAX) ? PCT_MAX : hsv.sat_pct;
    v_c = (hsv.val_pct > PCT_MAX) ? PCT_MAX : hsv.val_pct;
    priority if (h < 9'(SECTOR_DEG * 1)) sec = SEC_0;
    else if (h < 9'(SECTOR_DEG * 2))     sec = SEC_1;
    else if (h < 9'(SECTOR_DEG * 3))     sec = SEC_2;
    else if (h < 9'(SECTOR_DEG * 4))     sec = SEC_3;
    else if (h < 9'(SECTOR_DEG * 5))     sec = SEC_4;
    else                                 sec = SEC_5;
    off = h - 9'(9'(sec) * SECTOR_DEG);
    // falling edge of the triangle in odd sectors
    t_c = sec[0] ? 6'(SECTOR_DEG) - off[5:0] : off[5:0];
  end

  always_ff @(posedge clk) begin
    s1_s   <= s_c;
    s1_v   <= v_c;
    s1_t   <= t_c;
    s1_sec <= sec;
  end

  // stage 2: products of value
  always_ff @(posedge clk) begin
    s2_vs    <= 14'(s1_v) * 14'(s1_s);
    s2_v6000 <= NUM_W'(s1_v) * V_SCALE;
    s2_t     <= s1_t;
    s2_sec   <= s1_sec;
  end

  // stage 3: channel numerators over 600000
  assign lo_next  = s2_v6000 - NUM_W'(s2_vs) * VS_SCALE;
  assign mid_next = lo_next + NUM_W'(s2_vs) * NUM_W'(s2_t);

  always_ff @(posedge clk) begin
    hi_n   <= s2_v6000;
    lo_n   <= lo_next;
    mid_n  <= mid_next;
    s3_sec <= s2_sec;
  end

  // stages 4 and 5: scale to bytes
  hsv_scale u_scale_hi  (.clk(clk), .num(hi_n),  .chan(hi_b));
  hsv_scale u_scale_lo  (.clk(clk), .num(lo_n),  .chan(lo_b));
  hsv_scale u_scale_mid (.clk(clk), .num(mid_n), .chan(mid_b));

  always_ff @(posedge clk) begin
    s4_sec <= s3_sec;
    s5_sec <= s4_sec;
  end

  // stage 6: route channels by sector
  always_comb begin
    unique case (s5_sec)
      SEC_0:   grb_next = '{green: mid_b, red: hi_b,  blue: lo_b};
      SEC_1:   grb_next = '{green: hi_b,  red: mid_b, blue: lo_b};
      SEC_2:   grb_next = '{green: hi_b,  red: lo_b,  blue: mid_b};
      SEC_3:   grb_next = '{green: mid_b, red: lo_b,  blue: hi_b};
      SEC_4:   grb_next = '{green: lo_b,  red: mid_b, blue: hi_b};
      SEC_5:   grb_next = '{green: lo_b,  red: hi_b,  blue: mid_b};
      default: grb_next = '{green: lo_b,  red: hi_b,  blue: mid_b};
    endcase
  end

  always_ff @(posedge clk) begin
    grb <= grb_next;
  end

  // advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[3:0], start && !busy};
      done <= vld[4];
    end
  end

  `ASSERT_SEQ(a_beat_out, clk, rst, start && !busy, ##LAT done, "accepted beat not delivered")
  `ASSERT_SEQ(a_no_phantom, clk, rst, !start, ##LAT !done, "result beat without input")
  `ASSERT_IMPLIES(a_num_order, clk, rst, vld[2], (lo_n <= mid_n) && (mid_n <= hi_n), "numerators out of order")

endmodule
`default_nettype wire

// File: tb/hsv_to_grb_color_converter_tb.sv
// Self-checking testbench of the HSV to GRB color converter.
`timescale 1ns / 100ps
`default_nettype none
module hsv_to_grb_color_converter_tb;
  import hsv_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  hsv_t hsv = '0;
  logic busy;
  logic done;
  grb_t grb;

  grb_t expected_colors[$];
  int   idle_pct = 0;
  int   sent_count = 0;
  int   beats_checked = 0;
  int   error_count = 0;

  hsv_to_grb_color_converter u_top (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .hsv  (hsv),
    .done (done),
    .grb  (grb)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Scale a numerator over 600000 to a byte, truncating.
  function automatic logic [7:0] to_byte(input int unsigned num);
    return 8'((num * 255) / 600000);
  endfunction

  function automatic grb_t predict_grb(input hsv_t color);
    logic [8:0]  hue;
    int unsigned sat, val, hm, tri_deg, vs;
    logic [7:0]  hi, lo, mid;
    logic [2:0]  sector;
    grb_t        res;
    hue = (color.hue_deg >= HUE_FULL) ? color.hue_deg - HUE_FULL : color.hue_deg;
    sat = (color.sat_pct > PCT_MAX) ? PCT_MAX : color.sat_pct;
    val = (color.val_pct > PCT_MAX) ? PCT_MAX : color.val_pct;
    hm = hue % 120;
    tri_deg = (hm >= 60) ? 120 - hm : hm;
    vs = val * sat;
    hi  = to_byte(val * 6000);
    lo  = to_byte(val * 6000 - vs * 60);
    mid = to_byte(val * 6000 - vs * 60 + vs * tri_deg);
    sector = 3'(hue / 60);
    case (sector)
      SEC_0: begin res.red = hi;  res.green = mid; res.blue = lo;  end
      SEC_1: begin res.red = mid; res.green = hi;  res.blue = lo;  end
      SEC_2: begin res.red = lo;  res.green = hi;  res.blue = mid; end
      SEC_3: begin res.red = lo;  res.green = mid; res.blue = hi;  end
      SEC_4: begin res.red = mid; res.green = lo;  res.blue = hi;  end
      default: begin res.red = hi; res.green = lo; res.blue = mid; end
    endcase
    return res;
  endfunction

  function automatic hsv_t random_color();
    hsv_t c;
    // Mostly legal ranges; now and then the full field width to hit wrap and clamp.
    if ($urandom_range(99) < 85) begin
      c.hue_deg = 9'($urandom_range(359));
      c.sat_pct = 7'($urandom_range(100));
      c.val_pct = 7'($urandom_range(100));
    end else begin
      c.hue_deg = 9'($urandom_range(511));
      c.sat_pct = 7'($urandom_range(127));
      c.val_pct = 7'($urandom_range(127));
    end
    return c;
  endfunction

  task automatic report_field(input string name, input logic [7:0] exp_v,
                              input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  // Check each result beat against the oldest prediction.
  always @(posedge clk) begin
    grb_t exp_c;
    if (!rst && done) begin
      if (expected_colors.size() == 0) begin
        $display("%0t: result beat with none expected, actual g=%0d r=%0d b=%0d",
                 $time, grb.green, grb.red, grb.blue);
        error_count++;
      end else begin
        exp_c = expected_colors.pop_front();
        report_field("green", exp_c.green, grb.green);
        report_field("red", exp_c.red, grb.red);
        report_field("blue", exp_c.blue, grb.blue);
        beats_checked++;
      end
    end
  end

  task automatic send_color(input hsv_t color);
    // Idle each cycle with the chance given by idle_pct.
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      hsv <= random_color();
      @(posedge clk);
    end
    start <= 1'b1;
    hsv <= color;
    do @(posedge clk); while (busy);
    expected_colors.push_back(predict_grb(color));
    sent_count++;
  endtask

  // Hold the sender until every result is back, then let the pipe settle.
  task automatic wait_idle();
    start <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_sector_sweep();
    int hues[18] = '{0, 30, 59, 60, 90, 119, 120, 150, 179,
                     180, 210, 239, 240, 270, 299, 300, 330, 359};
    foreach (hues[i]) send_color('{hue_deg: 9'(hues[i]), sat_pct: 7'd100, val_pct: 7'd100});
  endtask

  task automatic test_special_inputs();
    send_color('{hue_deg: 9'd360, sat_pct: 7'd100, val_pct: 7'd100});
    send_color('{hue_deg: 9'd511, sat_pct: 7'd80, val_pct: 7'd90});
    send_color('{hue_deg: 9'd200, sat_pct: 7'd127, val_pct: 7'd50});
    send_color('{hue_deg: 9'd45, sat_pct: 7'd60, val_pct: 7'd127});
    send_color('{hue_deg: 9'd100, sat_pct: 7'd100, val_pct: 7'd0});
    send_color('{hue_deg: 9'd250, sat_pct: 7'd0, val_pct: 7'd100});
    send_color('{hue_deg: 9'd320, sat_pct: 7'd0, val_pct: 7'd37});
  endtask

  task automatic test_random_traffic(input int pct, input int count);
    idle_pct = pct;
    repeat (count) send_color(random_color());
  endtask

  task automatic test_drain_pause();
    repeat (12) send_color(random_color());
    wait_idle();
    repeat (12) send_color(random_color());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_sector_sweep();
    test_special_inputs();
    test_random_traffic(29, 120);
    test_drain_pause();
    test_random_traffic(62, 120);
    test_random_traffic(0, 130);
    wait_idle();
    $display("Sent %0d colors over all six hue sectors, wrapped hues and clamped inputs,",
             sent_count);
    $display("under three sender idle profiles; %0d result beats checked.", beats_checked);
    if (error_count == 0 && expected_colors.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("FAILURE");
    $finish;
  end

endmodule
`default_nettype wire
